// File: hdl/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// sbsh_pkg
// Types, constants and round constant table for the byte stream hasher.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_hash;

    typedef struct packed {
        logic       push;
        logic       full;
        logic       restart;
        logic [7:0] data;
    } t_core_ctl;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [7:0] PAD_ZERO      = 8'h00;
    localparam logic [5:0] PAD_END_BYTE  = 6'd56;
    localparam logic [5:0] LAST_BYTE     = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [2:0] LAST_LEN_BYTE = 3'd7;

    localparam t_hash HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// File: hdl/sbsh_core.sv
// ----------------------------------------------------------------------------
// sbsh_core
// Block shift register, message schedule window and one shared round unit
// that compresses a 64-byte block in 64 rounds followed by the chaining update.
// ----------------------------------------------------------------------------
module sbsh_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbsh_pkg::t_core_ctl i_ctl,
    output logic               o_busy,
    output sbsh_pkg::t_hash    o_hash
);

    function automatic sbsh_pkg::t_word rotr(input sbsh_pkg::t_word v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    logic [511:0]      r_blk;
    sbsh_pkg::t_hash   r_h;
    sbsh_pkg::t_hash   r_s;
    sbsh_pkg::t_hash   n_s;
    logic [5:0]        r_rnd;
    logic              r_busy;
    logic              r_fin;

    sbsh_pkg::t_word w0, w1, w9, w14, n_w;
    sbsh_pkg::t_word ssig0, ssig1, big0, big1, ch, maj, t1, t2;

    always_comb begin
        w0    = r_blk[511:480];
        w1    = r_blk[479:448];
        w9    = r_blk[223:192];
        w14   = r_blk[63:32];
        ssig0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        ssig1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        n_w   = ssig1 + w9 + ssig0 + w0;

        big1 = rotr(r_s[4], 6) ^ rotr(r_s[4], 11) ^ rotr(r_s[4], 25);
        ch   = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
        t1   = r_s[7] + big1 + ch + sbsh_pkg::round_k(r_rnd) + w0;
        big0 = rotr(r_s[0], 2) ^ rotr(r_s[0], 13) ^ rotr(r_s[0], 22);
        maj  = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
        t2   = big0 + maj;

        n_s[7] = r_s[6];
        n_s[6] = r_s[5];
        n_s[5] = r_s[4];
        n_s[4] = r_s[3] + t1;
        n_s[3] = r_s[2];
        n_s[2] = r_s[1];
        n_s[1] = r_s[0];
        n_s[0] = t1 + t2;
    end

    // control and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rnd  <= '0;
            r_h    <= sbsh_pkg::HASH_INIT;
        end else begin
            if (i_ctl.restart) begin
                r_h <= sbsh_pkg::HASH_INIT;
            end
            if (i_ctl.push && i_ctl.full) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_s[i];
                end
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == sbsh_pkg::LAST_ROUND) begin
                    r_fin <= 1'b1;
                end
            end
        end
    end

    // block window and working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_blk <= {r_blk[503:0], i_ctl.data};
            if (i_ctl.full) begin
                r_s <= r_h;
            end
        end else if (r_busy && !r_fin) begin
            r_blk <= {r_blk[479:0], n_w};
            r_s   <= n_s;
        end
    end

    assign o_busy = r_busy;
    assign o_hash = r_h;

endmodule

// File: hdl/sha256_byte_stream_hasher.sv
// a byte is taken on each accepted transaction that carries one; every 64th byte starts a
// compression that holds o_stall high for its 64 rounds of the shared round unit
// plus the chaining update. a closing transaction adds 9 to 72 padding bytes
// and one or two compressions, then eight digest word transactions.
// reset: synchronous active low, restores the initial hash values and clears
// the byte counters; the block buffer is not cleared
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// Byte intake, padding sequencer and digest output around the round core.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_P80   = 6'b000010,
        S_PZERO = 6'b000100,
        S_PLEN  = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [5:0]          r_bib, n_bib;
    logic [60:0]         r_cnt, n_cnt;
    logic [63:0]         r_len, n_len;
    logic [2:0]          r_lcnt, n_lcnt;
    logic [2:0]          r_widx, n_widx;
    sbsh_pkg::t_core_ctl ctl;
    sbsh_pkg::t_hash     hash;
    logic                busy;
    logic                in_acc;

    sbsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_busy  (busy),
        .o_hash  (hash)
    );

    assign o_stall = !((r_state == S_IDLE) && !busy);
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        n_bib   = r_bib;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_lcnt  = r_lcnt;
        n_widx  = r_widx;
        ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present) begin
                        ctl.push = 1'b1;
                        ctl.data = i_message_byte;
                        n_cnt    = r_cnt + 61'd1;
                    end
                    if (i_end_of_message) begin
                        n_len   = {n_cnt, 3'b000};
                        n_state = S_P80;
                    end
                end
            end
            S_P80: begin
                if (!busy) begin
                    ctl.push = 1'b1;
                    ctl.data = sbsh_pkg::PAD_MARK;
                    n_state  = S_PZERO;
                end
            end
            S_PZERO: begin
                if (!busy) begin
                    if (r_bib == sbsh_pkg::PAD_END_BYTE) begin
                        n_lcnt  = '0;
                        n_state = S_PLEN;
                    end else begin
                        ctl.push = 1'b1;
                        ctl.data = sbsh_pkg::PAD_ZERO;
                    end
                end
            end
            S_PLEN: begin
                if (!busy) begin
                    ctl.push = 1'b1;
                    ctl.data = r_len[63:56];
                    n_len    = {r_len[55:0], 8'h00};
                    n_lcnt   = r_lcnt + 3'd1;
                    if (r_lcnt == sbsh_pkg::LAST_LEN_BYTE) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!busy) begin
                    n_widx  = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == sbsh_pkg::LAST_WORD_IDX) begin
                        ctl.restart = 1'b1;
                        n_cnt       = '0;
                        n_bib       = '0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (ctl.push) begin
            ctl.full = (r_bib == sbsh_pkg::LAST_BYTE);
            n_bib    = r_bib + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bib   <= '0;
            r_cnt   <= '0;
            r_lcnt  <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_bib   <= n_bib;
            r_cnt   <= n_cnt;
            r_lcnt  <= n_lcnt;
            r_widx  <= n_widx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = hash[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == sbsh_pkg::LAST_WORD_IDX);

endmodule

// File: hdl/sbsh_checker.sv
// ----------------------------------------------------------------------------
// sbsh_checker
// Port level checks of the byte stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sbsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // no digest right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("digest valid after reset");

    // input side is held off while the digest is being delivered
    a_no_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during digest output");

    // words of one digest go out in order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_word |=>
            o_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word sequence broken");

    // last word flag marks the eighth word only
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last word flag misplaced");

    // stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hasher sbsh_checker u_sbsh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
